[hw/rtl/afpu_pkg.sv]
// Shared types and constants for the armed multichannel pulse firer.
// Holds command, error, register and channel-operation codes; no dependencies.
package afpu_pkg;

    localparam int REM_W  = 16;
    localparam int IDLE_W = 22;

    localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};

    // command codes carried in func
    localparam logic [3:0] FN_TICK      = 4'd0;
    localparam logic [3:0] FN_ARM       = 4'd1;
    localparam logic [3:0] FN_DISARM    = 4'd2;
    localparam logic [3:0] FN_ACTIVITY  = 4'd3;
    localparam logic [3:0] FN_FIRE_ONE  = 4'd4;
    localparam logic [3:0] FN_FIRE_MASK = 4'd5;
    localparam logic [3:0] FN_RAW_WRITE = 4'd6;
    localparam logic [3:0] FN_ESTOP     = 4'd7;
    localparam logic [3:0] FN_RELEASE   = 4'd8;

    // result error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_ESTOP     = 3'd1;
    localparam logic [2:0] ERR_NOT_ARMED = 3'd2;
    localparam logic [2:0] ERR_RANGE     = 3'd3;
    localparam logic [2:0] ERR_DURATION  = 3'd4;
    localparam logic [2:0] ERR_EMPTY     = 3'd5;
    localparam logic [2:0] ERR_LOCKED    = 3'd6;

    // configuration register indexes
    localparam logic [1:0] REG_MAX_PULSE    = 2'd0;
    localparam logic [1:0] REG_ARM_TIMEOUT  = 2'd1;
    localparam logic [1:0] REG_ACTIVE_LEVEL = 2'd2;

    localparam logic [15:0]       RST_MAX_PULSE    = 16'd1000;
    localparam logic [IDLE_W-1:0] RST_ARM_TIMEOUT  = 22'd30000;
    localparam logic              RST_ACTIVE_LEVEL = 1'b1;

    // per-channel operation applied during the sweep
    typedef logic [2:0] t_chan_op;
    localparam t_chan_op OP_NONE  = 3'd0;
    localparam t_chan_op OP_TICK  = 3'd1;
    localparam t_chan_op OP_LOAD  = 3'd2;
    localparam t_chan_op OP_RAW   = 3'd3;
    localparam t_chan_op OP_CLEAR = 3'd4;

    typedef struct packed {
        t_chan_op         op;
        logic             hit;          // this channel is addressed by the command
        logic             level_match;  // raw write level equals the active level
        logic [REM_W-1:0] dur;
    } t_chan_cmd;

endpackage

[hw/rtl/armed_multichannel_pulse_firer_unit.sv]
// Top level of the armed multichannel pulse firer: command decode, flags and channel sweep.
// Depends on afpu_pkg and afpu_chan_alu.
//
// Relay pulse controller for up to 32 channels with an arm interlock and an
// emergency-stop latch. Each input transfer on the s_axis side carries one command
// (tick, arm, disarm, activity, fire one, fire mask, raw write, estop, release)
// and yields exactly one result transfer on the m_axis side, holding the accept
// flag, error code, relay mask after the command, and the armed and estop states.
// Each command goes through a check state that decodes and checks it, a sweep that
// visits one channel per cycle through a single shared countdown unit, and a done
// state that loads the output register once it is free. The input is ready again
// only once that result sits in the output register, which holds it until the
// downstream side takes it. Configuration writes are taken at any cycle and are
// meant to happen only while no command is in flight. Reset clears all relays,
// countdowns, flags and the idle counter at once; no clearing pass is needed.
module armed_multichannel_pulse_firer_unit import afpu_pkg::*; #(
    parameter int CHANNELS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // s_axis tdata, from bit 0: func[3:0], channel[7:0], fire_mask[31:0],
    // duration_ms[15:0], pin_level, gpio_locked, two zero pad bits
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    // m_axis tdata, from bit 0: accepted, error_code[2:0], relay_mask[31:0],
    // armed_now, estop_now, two zero pad bits
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [21:0] i_cfg_data
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [31:0] CH_MASK = 32'((64'd1 << CHANNELS) - 64'd1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // control state
    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_armed, n_armed;
    logic             r_estop, n_estop;
    logic [IDLE_W-1:0] r_idle, n_idle;
    logic             r_out_valid, n_out_valid;

    // configuration
    logic [15:0]       r_max_pulse;
    logic [IDLE_W-1:0] r_timeout;
    logic              r_active;

    // channel state
    logic [31:0]      r_relay;
    logic [REM_W-1:0] r_rem [CHANNELS];

    // captured command
    logic [3:0]  r_func;
    logic [7:0]  r_chan;
    logic [31:0] r_mask;
    logic [15:0] r_dur;
    logic        r_pin;
    logic        r_locked;

    // per-command outcome
    logic       r_ok, n_ok;
    logic [2:0] r_err, n_err;
    t_chan_op   r_op, n_op;

    // output register payload
    logic        r_out_ok;
    logic [2:0]  r_out_err;
    logic [31:0] r_out_relay;
    logic        r_out_armed;
    logic        r_out_estop;

    logic in_xfer;
    logic out_load;

    // decode checks
    logic       w_chan_ok;
    logic       w_mask_empty;
    logic       w_dur_bad;
    logic [2:0] w_gate_err;
    logic       w_idle_inc;
    logic       w_idle_trip;

    // sweep datapath
    t_chan_cmd        w_cmd;
    logic             w_hit;
    logic [REM_W-1:0] w_rem_new;
    logic             w_closed_new;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_load      = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_estop, r_out_armed, r_out_relay, r_out_err, r_out_ok};

    assign w_chan_ok    = (r_chan != 8'd0) && (r_chan <= 8'(CHANNELS));
    assign w_mask_empty = (r_mask & CH_MASK) == 32'd0;
    assign w_dur_bad    = (r_dur == 16'd0) || (r_dur > r_max_pulse);
    assign w_gate_err   = r_estop ? ERR_ESTOP : (!r_armed ? ERR_NOT_ARMED : ERR_NONE);

    // The counter steps while at or below the timeout and short of saturation;
    // the block trips once the stepped value lies above the timeout.
    assign w_idle_inc  = (r_idle != IDLE_MAX) && (r_idle <= r_timeout);
    assign w_idle_trip = (r_idle > r_timeout) || ((r_idle == r_timeout) && (r_idle != IDLE_MAX));

    // Address match for the channel under the sweep: a mask bit for fire mask,
    // the one-based channel number otherwise.
    assign w_hit = (r_func == FN_FIRE_MASK) ? r_mask[r_idx]
                                            : (8'(r_idx) == (r_chan - 8'd1));

    assign w_cmd = '{op: r_op, hit: w_hit, level_match: (r_pin == r_active), dur: r_dur};

    afpu_chan_alu u_alu (
        .i_cmd    (w_cmd),
        .i_rem    (r_rem[r_idx]),
        .i_closed (r_relay[r_idx]),
        .o_rem    (w_rem_new),
        .o_closed (w_closed_new)
    );

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_armed     = r_armed;
        n_estop     = r_estop;
        n_idle      = r_idle;
        n_ok        = r_ok;
        n_err       = r_err;
        n_op        = r_op;
        n_out_valid = r_out_valid;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // decide outcome and flags; the sweep then applies n_op per channel
                n_ok  = 1'b1;
                n_err = ERR_NONE;
                n_op  = OP_NONE;
                n_idx = '0;
                case (r_func)
                    FN_TICK: begin
                        n_op = OP_TICK;
                        if (r_armed) begin
                            if (w_idle_inc) begin
                                n_idle = r_idle + IDLE_W'(1);
                            end
                            if (w_idle_trip) begin
                                n_armed = 1'b0;
                            end
                        end
                    end
                    FN_ARM: begin
                        if (r_estop) begin
                            n_armed = 1'b0;
                            n_ok    = 1'b0;
                            n_err   = ERR_ESTOP;
                        end else begin
                            n_armed = 1'b1;
                            n_idle  = '0;
                        end
                    end
                    FN_DISARM: begin
                        n_armed = 1'b0;
                        n_idle  = '0;
                    end
                    FN_ACTIVITY: begin
                        n_idle = '0;
                    end
                    FN_FIRE_ONE, FN_FIRE_MASK: begin
                        if (w_gate_err != ERR_NONE) begin
                            n_err = w_gate_err;
                        end else if (r_func == FN_FIRE_ONE && !w_chan_ok) begin
                            n_err = ERR_RANGE;
                        end else if (r_func == FN_FIRE_MASK && w_mask_empty) begin
                            n_err = ERR_EMPTY;
                        end else if (w_dur_bad) begin
                            n_err = ERR_DURATION;
                        end
                        if (n_err == ERR_NONE) begin
                            n_op   = OP_LOAD;
                            n_idle = '0;
                        end else begin
                            n_ok = 1'b0;
                        end
                    end
                    FN_RAW_WRITE: begin
                        if (r_locked) begin
                            n_ok  = 1'b0;
                            n_err = ERR_LOCKED;
                        end else if (!w_chan_ok) begin
                            n_ok  = 1'b0;
                            n_err = ERR_RANGE;
                        end else begin
                            n_op = OP_RAW;
                        end
                    end
                    FN_ESTOP: begin
                        n_estop = 1'b1;
                        n_armed = 1'b0;
                        n_op    = OP_CLEAR;
                    end
                    FN_RELEASE: begin
                        n_estop = 1'b0;
                    end
                    default: begin
                        n_ok = 1'b0;
                    end
                endcase
                n_state = ST_SWEEP;
            end
            ST_SWEEP: begin
                // advance one channel per cycle
                if (r_idx == LAST_IDX) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_armed     <= 1'b0;
            r_estop     <= 1'b0;
            r_idle      <= '0;
            r_out_valid <= 1'b0;
            r_ok        <= 1'b0;
            r_err       <= ERR_NONE;
            r_op        <= OP_NONE;
            r_relay     <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_rem[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_armed     <= n_armed;
            r_estop     <= n_estop;
            r_idle      <= n_idle;
            r_out_valid <= n_out_valid;
            r_ok        <= n_ok;
            r_err       <= n_err;
            r_op        <= n_op;
            if (r_state == ST_SWEEP) begin
                r_rem[r_idx]   <= w_rem_new;
                r_relay[r_idx] <= w_closed_new;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_pulse <= RST_MAX_PULSE;
            r_timeout   <= RST_ARM_TIMEOUT;
            r_active    <= RST_ACTIVE_LEVEL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MAX_PULSE:    r_max_pulse <= i_cfg_data[15:0];
                REG_ARM_TIMEOUT:  r_timeout   <= i_cfg_data;
                REG_ACTIVE_LEVEL: r_active    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // hold the command fields for the whole item
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_func   <= s_axis_tdata[3:0];
            r_chan   <= s_axis_tdata[11:4];
            r_mask   <= s_axis_tdata[43:12];
            r_dur    <= s_axis_tdata[59:44];
            r_pin    <= s_axis_tdata[60];
            r_locked <= s_axis_tdata[61];
        end
    end

    // result payload, loaded once the sweep has finished
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_ok    <= r_ok;
            r_out_err   <= r_err;
            r_out_relay <= r_relay;
            r_out_armed <= r_armed && !r_estop;
            r_out_estop <= r_estop;
        end
    end

    // armed and estop never hold together: estop drops arm, arm fails under estop
    a_arm_estop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_armed && r_estop))
        else $error("armed and estop latched at once");

    // relay bits beyond the channel count stay open
    a_relay_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_relay & ~CH_MASK) == 32'd0)
        else $error("relay closed beyond channel count");

    // an accepted command never carries an error code
    a_ok_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_ok |-> r_out_err == ERR_NONE)
        else $error("accepted result with error code");

    // after an input transfer the block stays busy on that command
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !s_axis_tready && r_state == ST_CHECK)
        else $error("input ready right after a transfer");

endmodule

[hw/rtl/afpu_chan_alu.sv]
// Shared per-channel update unit: countdown decrement, load, raw set and clear.
// Depends on afpu_pkg.
module afpu_chan_alu import afpu_pkg::*; (
    input  t_chan_cmd        i_cmd,
    input  logic [REM_W-1:0] i_rem,
    input  logic             i_closed,
    output logic [REM_W-1:0] o_rem,
    output logic             o_closed
);

    always_comb begin
        o_rem    = i_rem;
        o_closed = i_closed;
        case (i_cmd.op)
            OP_TICK: begin
                // open the relay on the step that lands on zero
                if (i_rem != '0) begin
                    o_rem = i_rem - REM_W'(1);
                    if (i_rem == REM_W'(1)) begin
                        o_closed = 1'b0;
                    end
                end
            end
            OP_LOAD: begin
                if (i_cmd.hit) begin
                    o_closed = 1'b1;
                    o_rem    = i_cmd.dur;
                end
            end
            OP_RAW: begin
                if (i_cmd.hit) begin
                    o_closed = i_cmd.level_match;
                    o_rem    = '0;
                end
            end
            OP_CLEAR: begin
                o_closed = 1'b0;
                o_rem    = '0;
            end
            default: begin
            end
        endcase
    end

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for armed_multichannel_pulse_firer_unit: directed command script,
// then randomized phases, checked against hand-typed replies or an in-bench relay predictor.
// Depends on afpu_pkg and the RTL of the firer unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import afpu_pkg::*;

    localparam int N_CHANNELS     = 32;
    localparam int SETTLE_CYCLES  = 40;    // idle margin after the awaited replies have drained
    localparam int WATCHDOG_LIMIT = 3000;  // cycles without any transfer on either side
    localparam int ITEMS_PER_PHASE = 160;
    localparam int N_PHASES        = 8;

    // s_axis tdata body, from bit 0: func, channel, fire_mask, duration_ms, pin_level, gpio_locked
    typedef struct packed {
        logic        locked;
        logic        level;
        logic [15:0] dur;
        logic [31:0] mask;
        logic [7:0]  channel;
        logic [3:0]  func;
    } t_firer_cmd;

    // m_axis tdata body, from bit 0: accepted, error_code, relay_mask, armed_now, estop_now
    typedef struct packed {
        logic        estop;
        logic        armed;
        logic [31:0] relays;
        logic [2:0]  err;
        logic        accepted;
    } t_firer_reply;

    // one line of the directed script: a register write or a command, with an optional
    // hand-typed reply
    typedef struct {
        bit           is_cfg;
        logic [1:0]   reg_idx;
        logic [21:0]  reg_val;
        t_firer_cmd   cmd;
        bit           typed;
        t_firer_reply want;
    } t_script_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // func[3:0], channel[7:0], fire_mask[31:0], duration_ms[15:0], pin_level, gpio_locked, pad
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // accepted, error_code[2:0], relay_mask[31:0], armed_now, estop_now, pad
    logic [39:0] m_axis_tdata;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [21:0] i_cfg_data;

    armed_multichannel_pulse_firer_unit #(
        .CHANNELS(N_CHANNELS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // Predictor state: configuration copy and per-channel relay bookkeeping
    logic [15:0]       max_pulse;
    logic [IDLE_W-1:0] arm_timeout;
    logic              active_lvl;
    logic [31:0]       relay_closed;
    logic [15:0]       pulse_left [N_CHANNELS];
    logic              armed_flag;
    logic              estop_flag;
    logic [IDLE_W-1:0] idle_count;

    t_firer_reply awaited_replies[$];
    t_script_row  script_rows[$];
    int           mismatch_count;
    int           stall_left;
    int           quiet_cycles;
    bit           steady_phase;   // no gaps and no stalls during this phase

    always #1 i_clk = ~i_clk;

    // Apply one command to the predictor state and return the reply it produces.
    function automatic t_firer_reply predict_command_reply(input t_firer_cmd c);
        t_firer_reply r;
        logic [2:0]   err;
        logic         ok;
        err = ERR_NONE;
        ok  = 1'b1;
        case (c.func)
            FN_TICK: begin
                for (int i = 0; i < N_CHANNELS; i++) begin
                    if (pulse_left[i] != 16'd0) begin
                        pulse_left[i] = pulse_left[i] - 16'd1;
                        if (pulse_left[i] == 16'd0) relay_closed[i] = 1'b0;
                    end
                end
                // idle counter saturates one past the timeout, and at its full width
                if (armed_flag) begin
                    if (idle_count < IDLE_MAX && idle_count <= arm_timeout)
                        idle_count = idle_count + IDLE_W'(1);
                    if (idle_count > arm_timeout) armed_flag = 1'b0;
                end
            end
            FN_ARM: begin
                if (estop_flag) begin
                    armed_flag = 1'b0;
                    err = ERR_ESTOP;
                end else begin
                    armed_flag = 1'b1;
                    idle_count = '0;
                end
            end
            FN_DISARM: begin
                armed_flag = 1'b0;
                idle_count = '0;
            end
            FN_ACTIVITY: idle_count = '0;
            FN_FIRE_ONE, FN_FIRE_MASK: begin
                if (estop_flag) err = ERR_ESTOP;
                else if (!armed_flag) err = ERR_NOT_ARMED;
                else if (c.func == FN_FIRE_ONE && (c.channel < 1 || c.channel > N_CHANNELS))
                    err = ERR_RANGE;
                else if (c.func == FN_FIRE_MASK && c.mask == 32'd0) err = ERR_EMPTY;
                else if (c.dur == 16'd0 || c.dur > max_pulse) err = ERR_DURATION;
                if (err == ERR_NONE) begin
                    for (int i = 0; i < N_CHANNELS; i++) begin
                        if ((c.func == FN_FIRE_ONE && i == int'(c.channel) - 1) ||
                            (c.func == FN_FIRE_MASK && c.mask[i])) begin
                            relay_closed[i] = 1'b1;
                            pulse_left[i]   = c.dur;
                        end
                    end
                    idle_count = '0;
                end
            end
            FN_RAW_WRITE: begin
                // raw writes ignore estop and arm state; lock first, then range
                if (c.locked) err = ERR_LOCKED;
                else if (c.channel < 1 || c.channel > N_CHANNELS) err = ERR_RANGE;
                if (err == ERR_NONE) begin
                    relay_closed[c.channel - 1] = (c.level == active_lvl);
                    pulse_left[c.channel - 1]   = 16'd0;
                end
            end
            FN_ESTOP: begin
                estop_flag   = 1'b1;
                armed_flag   = 1'b0;
                relay_closed = '0;
                for (int i = 0; i < N_CHANNELS; i++) pulse_left[i] = 16'd0;
            end
            FN_RELEASE: estop_flag = 1'b0;
            default: ok = 1'b0;
        endcase
        if (err != ERR_NONE) ok = 1'b0;
        r.accepted = ok;
        r.err      = err;
        r.relays   = relay_closed;
        r.armed    = armed_flag && !estop_flag;
        r.estop    = estop_flag;
        return r;
    endfunction

    function automatic t_script_row cmd_row(input logic [3:0] fn, input logic [7:0] ch,
                                            input logic [31:0] msk, input logic [15:0] d,
                                            input logic lv, input logic lk);
        t_script_row row;
        row = '{default: '0};
        row.cmd.func    = fn;
        row.cmd.channel = ch;
        row.cmd.mask    = msk;
        row.cmd.dur     = d;
        row.cmd.level   = lv;
        row.cmd.locked  = lk;
        return row;
    endfunction

    function automatic t_script_row with_reply(input t_script_row row, input logic acc,
                                               input logic [2:0] e, input logic [31:0] rel,
                                               input logic arm, input logic es);
        row.typed         = 1'b1;
        row.want.accepted = acc;
        row.want.err      = e;
        row.want.relays   = rel;
        row.want.armed    = arm;
        row.want.estop    = es;
        return row;
    endfunction

    function automatic t_script_row cfg_row(input logic [1:0] idx, input logic [21:0] v);
        t_script_row row;
        row = '{default: '0};
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = v;
        return row;
    endfunction

    // Mostly short gaps, now and then a long one; none in a steady phase.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_phase || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Random command, biased toward well-formed fire and tick traffic.
    function automatic t_firer_cmd pick_command();
        t_firer_cmd c;
        int         r;
        int         small_max;
        small_max = (max_pulse < 12) ? int'(max_pulse) : 12;
        // start from fully random fields so every bit toggles, then shape them
        c.func    = 4'($urandom());
        c.channel = 8'($urandom());
        c.mask    = $urandom();
        c.dur     = 16'($urandom());
        c.level   = 1'($urandom());
        c.locked  = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        if (r < 28) c.func = FN_TICK;
        else if (r < 36) c.func = FN_ARM;
        else if (r < 38) c.func = FN_DISARM;
        else if (r < 42) c.func = FN_ACTIVITY;
        else if (r < 60) c.func = FN_FIRE_ONE;
        else if (r < 72) c.func = FN_FIRE_MASK;
        else if (r < 84) c.func = FN_RAW_WRITE;
        else if (r < 87) c.func = FN_ESTOP;
        else if (r < 92) c.func = FN_RELEASE;
        else if (r < 96) c.func = 4'($urandom_range(9, 15));
        if ($urandom_range(0, 99) < 85) c.channel = 8'($urandom_range(1, N_CHANNELS));
        r = $urandom_range(0, 99);
        if (r < 80) c.dur = 16'($urandom_range(1, small_max));
        else if (r < 85) c.dur = max_pulse;
        else if (r < 90) c.dur = max_pulse + 16'd1;
        r = $urandom_range(0, 99);
        if (r < 25) c.mask = 32'd1 << $urandom_range(0, 31);
        else if (r < 40) c.mask = c.mask & $urandom() & $urandom();
        else if (r < 50) c.mask = 32'd0;
        return c;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Compare one result transfer against the oldest awaited reply.
    task automatic check_reply(input t_firer_reply got);
        t_firer_reply want;
        if (awaited_replies.size() == 0) begin
            report_mismatch($sformatf("result transfer with no command pending: %h", got));
            return;
        end
        want = awaited_replies.pop_front();
        if (got.accepted !== want.accepted)
            report_mismatch($sformatf("accepted %b, want %b", got.accepted, want.accepted));
        if (got.err !== want.err)
            report_mismatch($sformatf("error_code %0d, want %0d", got.err, want.err));
        if (got.relays !== want.relays)
            report_mismatch($sformatf("relay_mask %h, want %h", got.relays, want.relays));
        if (got.armed !== want.armed)
            report_mismatch($sformatf("armed_now %b, want %b", got.armed, want.armed));
        if (got.estop !== want.estop)
            report_mismatch($sformatf("estop_now %b, want %b", got.estop, want.estop));
    endtask

    // Present one command, hold it until the transfer, then optionally idle.
    // Entered and left at a falling edge.
    task automatic send_command(input t_firer_cmd cmd, input bit typed,
                                input t_firer_reply typed_reply);
        t_firer_reply reply;
        int           gap;
        s_axis_tdata  <= {2'b00, cmd};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        reply = predict_command_reply(cmd);
        awaited_replies.push_back(typed ? typed_reply : reply);
        @(negedge i_clk);
        gap = pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Drop valid, drain every pending reply, then let the pipeline settle.
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        while (awaited_replies.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write one register and mirror it into the predictor; the enable is dropped again so that
    // back-to-back writes never assign the enable twice in one step.
    task automatic write_reg(input logic [1:0] idx, input logic [21:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        case (idx)
            REG_MAX_PULSE:    max_pulse   = val[15:0];
            REG_ARM_TIMEOUT:  arm_timeout = val;
            REG_ACTIVE_LEVEL: active_lvl  = val[0];
            default: ;
        endcase
    endtask

    // Downstream ready: stall at random, holding each stall for its full length.
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    // Sample result transfers at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) check_reply(m_axis_tdata[37:0]);
    end

    // Watchdog: end the run once nothing has moved on either side for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        logic [15:0]       pulse_pick;
        logic [IDLE_W-1:0] timeout_pick;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        mismatch_count = 0;
        stall_left     = 0;
        quiet_cycles   = 0;
        steady_phase   = 1'b0;

        // predictor starts from the reset state
        max_pulse    = RST_MAX_PULSE;
        arm_timeout  = RST_ARM_TIMEOUT;
        active_lvl   = RST_ACTIVE_LEVEL;
        relay_closed = '0;
        for (int i = 0; i < N_CHANNELS; i++) pulse_left[i] = 16'd0;
        armed_flag = 1'b0;
        estop_flag = 1'b0;
        idle_count = '0;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed script, reset configuration first: gate order, range and duration
        // limits, raw writes, estop latch, then timeout corner cases.
        script_rows.push_back(with_reply(cmd_row(FN_TICK, 8'd0, 32'd0, 16'd0, 1'b0, 1'b0),
                                         1'b1, ERR_NONE, 32'd0, 1'b0, 1'b0));
        script_rows.push_back(with_reply(cmd_row(FN_FIRE_ONE, 8'd1, 32'd0, 16'd5, 1'b0, 1'b0),
                                         1'b0, ERR_NOT_ARMED, 32'd0, 1'b0, 1'b0));
        // unknown command with every field bit set: nothing happens
        script_rows.push_back(with_reply(cmd_row(4'd15, 8'hFF, '1, '1, 1'b1, 1'b1),
                                         1'b0, ERR_NONE, 32'd0, 1'b0, 1'b0));
        script_rows.push_back(with_reply(cmd_row(FN_ARM, 8'd0, 32'd0, 16'd0, 1'b0, 1'b0),
                                         1'b1, ERR_NONE, 32'd0, 1'b1, 1'b0));
        script_rows.push_back(with_reply(cmd_row(FN_FIRE_ONE, 8'd0, 32'd0, 16'd5, 1'b0, 1'b0),
                                         1'b0, ERR_RANGE, 32'd0, 1'b1, 1'b0));
        script_rows.push_back(with_reply(cmd_row(FN_FIRE_ONE, 8'd33, 32'd0, 16'd5, 1'b0, 1'b0),
                                         1'b0, ERR_RANGE, 32'd0, 1'b1, 1'b0));
        script_rows.push_back(with_reply(cmd_row(FN_FIRE_ONE, 8'd1, 32'd0, 16'd0, 1'b0, 1'b0),
                                         1'b0, ERR_DURATION, 32'd0, 1'b1, 1'b0));
        script_rows.push_back(with_reply(cmd_row(FN_FIRE_ONE, 8'd1, 32'd0, 16'd1001, 1'b0, 1'b0),
                                         1'b0, ERR_DURATION, 32'd0, 1'b1, 1'b0));
        script_rows.push_back(with_reply(cmd_row(FN_FIRE_MASK, 8'd0, 32'd0, 16'd5, 1'b0, 1'b0),
                                         1'b0, ERR_EMPTY, 32'd0, 1'b1, 1'b0));
        script_rows.push_back(with_reply(cmd_row(FN_FIRE_ONE, 8'd1, 32'd0, 16'd1, 1'b0, 1'b0),
                                         1'b1, ERR_NONE, 32'h0000_0001, 1'b1, 1'b0));
        script_rows.push_back(with_reply(cmd_row(FN_FIRE_ONE, 8'd32, 32'd0, 16'd1000, 1'b0, 1'b0),
                                         1'b1, ERR_NONE, 32'h8000_0001, 1'b1, 1'b0));
        script_rows.push_back(with_reply(cmd_row(FN_TICK, 8'd0, 32'd0, 16'd0, 1'b0, 1'b0),
                                         1'b1, ERR_NONE, 32'h8000_0000, 1'b1, 1'b0));
        script_rows.push_back(with_reply(cmd_row(FN_FIRE_MASK, 8'd0, '1, 16'd2, 1'b0, 1'b0),
                                         1'b1, ERR_NONE, '1, 1'b1, 1'b0));
        script_rows.push_back(with_reply(cmd_row(FN_RAW_WRITE, 8'd5, 32'd0, 16'd0, 1'b1, 1'b1),
                                         1'b0, ERR_LOCKED, '1, 1'b1, 1'b0));
        script_rows.push_back(with_reply(cmd_row(FN_RAW_WRITE, 8'd0, 32'd0, 16'd0, 1'b1, 1'b0),
                                         1'b0, ERR_RANGE, '1, 1'b1, 1'b0));
        script_rows.push_back(with_reply(cmd_row(FN_RAW_WRITE, 8'd5, 32'd0, 16'd0, 1'b0, 1'b0),
                                         1'b1, ERR_NONE, 32'hFFFF_FFEF, 1'b1, 1'b0));
        // a raw-closed relay has no countdown and survives the ticks that expire the rest
        script_rows.push_back(cmd_row(FN_RAW_WRITE, 8'd5, 32'd0, 16'd0, 1'b1, 1'b0));
        script_rows.push_back(cmd_row(FN_TICK, 8'd0, 32'd0, 16'd0, 1'b0, 1'b0));
        script_rows.push_back(cmd_row(FN_TICK, 8'd0, 32'd0, 16'd0, 1'b0, 1'b0));
        script_rows.push_back(with_reply(cmd_row(FN_ESTOP, 8'd0, 32'd0, 16'd0, 1'b0, 1'b0),
                                         1'b1, ERR_NONE, 32'd0, 1'b0, 1'b1));
        script_rows.push_back(with_reply(cmd_row(FN_ARM, 8'd0, 32'd0, 16'd0, 1'b0, 1'b0),
                                         1'b0, ERR_ESTOP, 32'd0, 1'b0, 1'b1));
        script_rows.push_back(with_reply(cmd_row(FN_FIRE_MASK, 8'd0, 32'd3, 16'd5, 1'b0, 1'b0),
                                         1'b0, ERR_ESTOP, 32'd0, 1'b0, 1'b1));
        // raw write is allowed even with the latch set
        script_rows.push_back(cmd_row(FN_RAW_WRITE, 8'd3, 32'd0, 16'd0, 1'b1, 1'b0));
        script_rows.push_back(cmd_row(FN_RELEASE, 8'd0, 32'd0, 16'd0, 1'b0, 1'b0));
        script_rows.push_back(cmd_row(FN_DISARM, 8'd0, 32'd0, 16'd0, 1'b0, 1'b0));
        // timeout of one: second idle tick drops the arm
        script_rows.push_back(cfg_row(REG_ARM_TIMEOUT, 22'd1));
        script_rows.push_back(cmd_row(FN_ARM, 8'd0, 32'd0, 16'd0, 1'b0, 1'b0));
        script_rows.push_back(cmd_row(FN_TICK, 8'd0, 32'd0, 16'd0, 1'b0, 1'b0));
        script_rows.push_back(cmd_row(FN_TICK, 8'd0, 32'd0, 16'd0, 1'b0, 1'b0));
        // zero timeout disarms on the first tick; widest pulse and inverted pin level
        script_rows.push_back(cfg_row(REG_ARM_TIMEOUT, 22'd0));
        script_rows.push_back(cfg_row(REG_MAX_PULSE, 22'd65535));
        script_rows.push_back(cfg_row(REG_ACTIVE_LEVEL, 22'd0));
        script_rows.push_back(cmd_row(FN_ARM, 8'd0, 32'd0, 16'd0, 1'b0, 1'b0));
        script_rows.push_back(cmd_row(FN_FIRE_ONE, 8'd16, 32'd0, 16'd65535, 1'b0, 1'b0));
        script_rows.push_back(cmd_row(FN_RAW_WRITE, 8'd9, 32'd0, 16'd0, 1'b0, 1'b0));
        script_rows.push_back(cmd_row(FN_TICK, 8'd0, 32'd0, 16'd0, 1'b0, 1'b0));

        foreach (script_rows[n]) begin
            if (script_rows[n].is_cfg) begin
                settle_idle();
                write_reg(script_rows[n].reg_idx, script_rows[n].reg_val);
            end else begin
                send_command(script_rows[n].cmd, script_rows[n].typed, script_rows[n].want);
            end
        end

        // Random phases: reprogram all registers between phases, sweeping the extremes.
        for (int phase = 0; phase < N_PHASES; phase++) begin
            case (phase % 4)
                0:       pulse_pick = 16'd1;
                1:       pulse_pick = 16'd65535;
                2:       pulse_pick = 16'($urandom_range(2, 20));
                default: pulse_pick = RST_MAX_PULSE;
            endcase
            case (phase % 5)
                0:       timeout_pick = IDLE_W'($urandom_range(1, 40));
                1:       timeout_pick = 22'd1;
                2:       timeout_pick = 22'd3600000;
                3:       timeout_pick = IDLE_W'($urandom_range(2, 12));
                default: timeout_pick = IDLE_MAX;   // auto-disarm can never trigger
            endcase
            settle_idle();
            write_reg(REG_MAX_PULSE, 22'(pulse_pick));
            write_reg(REG_ARM_TIMEOUT, timeout_pick);
            write_reg(REG_ACTIVE_LEVEL, 22'(phase % 2));
            steady_phase = (phase % 3 == 2);
            repeat (ITEMS_PER_PHASE) send_command(pick_command(), 1'b0, '0);
        end

        settle_idle();
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
hw/rtl/afpu_pkg.sv
hw/rtl/afpu_chan_alu.sv
hw/rtl/armed_multichannel_pulse_firer_unit.sv
tb/sv/tb.sv
